>>> hdl/bfpt_pkg.sv
// Shared constants, types and helpers for the binomial threshold search.
`default_nettype none

package bfpt_pkg;

    localparam int MAX_N      = 1023;
    localparam int TBL_DEPTH  = MAX_N + 1;
    localparam int TBL_AW     = $clog2(TBL_DEPTH);
    localparam int TBL_DW     = 32;
    localparam int N_W        = 10;
    localparam int CORR_W     = 10;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int K_W        = $clog2(MAX_N + 2);
    localparam int ACC_W      = 48;
    localparam int SUM_W      = ACC_W + 2;
    localparam int FRAC_BITS  = 24;
    localparam int MANT_FRAC  = 30;
    localparam int MANT_W     = MANT_FRAC + 1;
    localparam int EXP_W      = $clog2(TBL_AW);
    localparam int SHIFT_W    = $clog2(MANT_W);
    localparam int BIT_CNT_W  = $clog2(FRAC_BITS + 1);
    localparam int PROD_W     = TBL_AW + 1 + CFG_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LOG_FALSE_RATE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_TRUE_RATE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_PROB_LIMIT = CFG_IDX_W'(2);

    localparam logic signed [CFG_W-1:0] LOG_FALSE_RATE_RST = -32'sd72509891;
    localparam logic signed [CFG_W-1:0] LOG_TRUE_RATE_RST  = -32'sd1241534;
    localparam logic signed [CFG_W-1:0] LOG_PROB_LIMIT_RST = -32'sd45918669;

    typedef struct packed {
        logic signed [CFG_W-1:0] log_false_rate;
        logic signed [CFG_W-1:0] log_true_rate;
        logic signed [CFG_W-1:0] log_prob_limit;
    } rate_cfg_t;

    typedef struct packed {
        logic              en;
        logic [TBL_AW-1:0] addr;
        logic [TBL_DW-1:0] data;
    } tbl_wr_t;

    typedef struct packed {
        logic [TBL_AW-1:0] addr_a;
        logic [TBL_AW-1:0] addr_b;
    } tbl_rd_t;

    typedef enum logic [2:0] {
        FILL_ZERO,
        FILL_NORM,
        FILL_SQUARE,
        FILL_WRITE,
        FILL_DONE
    } fill_state_t;

    typedef enum logic [2:0] {
        SRCH_IDLE,
        SRCH_LOAD,
        SRCH_INIT,
        SRCH_TEST,
        SRCH_ADD,
        SRCH_DONE
    } srch_state_t;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        logic signed [ACC_W-1:0] res;
        if ((v[SUM_W-1:ACC_W-1] == '0) || (v[SUM_W-1:ACC_W-1] == '1)) begin
            res = v[ACC_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(ACC_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hdl/binomial_false_positive_threshold.sv
// Top level of the binomial tail threshold search.
//
// Usage: software writes log2(fpr), log2(1-fpr) and log2(p_max) in signed Q8.24
// through cfg_we / cfg_index / cfg_wdata while the block is idle. Each input
// transaction on s_* carries a minimizer count n; each output transaction on m_*
// returns the largest tolerated false positive count and a saturation flag.
// After reset the block sweeps the log2 table one entry at a time; s_ready
// stays low until the sweep is done, while configuration writes are taken at
// once.
// A zero count skips the search; otherwise the search runs one trial count at a
// time, each a table read followed by two saturating accumulator adds. A new
// transaction is taken in the cycle after the result has moved to the output
// register.
// One item is in work at a time. A result waits in the output register while
// m_ready is low; the search holds its finished result until that register frees.
`default_nettype none

module binomial_false_positive_threshold
    import bfpt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [N_W-1:0]       s_minimizer_count,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [CORR_W-1:0]         m_correction,
    output logic                      m_saturated,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    rate_cfg_t         cfg_reg, cfg_next;
    tbl_wr_t           wr;
    tbl_rd_t           rd_req;
    logic              fill_done;
    logic [TBL_DW-1:0] rdata_a;
    logic [TBL_DW-1:0] rdata_b;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_LOG_FALSE_RATE: cfg_next.log_false_rate = $signed(cfg_wdata);
                CFG_LOG_TRUE_RATE:  cfg_next.log_true_rate  = $signed(cfg_wdata);
                CFG_LOG_PROB_LIMIT: cfg_next.log_prob_limit = $signed(cfg_wdata);
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.log_false_rate <= LOG_FALSE_RATE_RST;
            cfg_reg.log_true_rate  <= LOG_TRUE_RATE_RST;
            cfg_reg.log_prob_limit <= LOG_PROB_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    bfpt_log_fill u_fill (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (wr),
        .fill_done (fill_done)
    );

    bfpt_table_ram #(
        .DEPTH (TBL_DEPTH),
        .WIDTH (TBL_DW)
    ) u_table (
        .aclk    (aclk),
        .we      (wr.en),
        .waddr   (wr.addr),
        .wdata   (wr.data),
        .raddr_a (rd_req.addr_a),
        .raddr_b (rd_req.addr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    bfpt_search u_search (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .fill_done         (fill_done),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_minimizer_count (s_minimizer_count),
        .rd_req            (rd_req),
        .rdata_a           (rdata_a),
        .rdata_b           (rdata_b),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_correction      (m_correction),
        .m_saturated       (m_saturated)
    );

endmodule

`default_nettype wire

>>> hdl/bfpt_table_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module bfpt_table_ram #(
    parameter  int DEPTH = 1024,
    parameter  int WIDTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

>>> hdl/bfpt_log_fill.sv
// Sequential log2 generator that fills the log table after reset.
`default_nettype none

module bfpt_log_fill
    import bfpt_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    output tbl_wr_t   wr,
    output logic      fill_done
);

    fill_state_t            state_reg, state_next;
    logic [TBL_AW-1:0]      idx_reg, idx_next;
    logic [MANT_W-1:0]      mant_reg, mant_next;
    logic [TBL_DW-1:0]      res_reg, res_next;
    logic [BIT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [EXP_W-1:0]       msb;
    logic [SHIFT_W-1:0]     shamt;
    logic [2*MANT_W-1:0]    square;
    logic [MANT_W:0]        sq_top;

    always_comb begin
        msb = '0;
        for (int b = 0; b < TBL_AW; b++) begin
            if (idx_reg[b]) begin
                msb = EXP_W'(b);
            end
        end
    end

    assign shamt  = SHIFT_W'(MANT_FRAC) - SHIFT_W'(msb);
    assign square = (2*MANT_W)'(mant_reg) * (2*MANT_W)'(mant_reg);
    assign sq_top = square[MANT_FRAC +: MANT_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FILL_ZERO;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
        mant_reg <= mant_next;
        res_reg  <= res_next;
        cnt_reg  <= cnt_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FILL_ZERO:   state_next = FILL_NORM;
            FILL_NORM:   state_next = FILL_SQUARE;
            FILL_SQUARE: begin
                if (cnt_reg == BIT_CNT_W'(1)) begin
                    state_next = FILL_WRITE;
                end
            end
            FILL_WRITE: begin
                if (int'(idx_reg) == MAX_N) begin
                    state_next = FILL_DONE;
                end else begin
                    state_next = FILL_NORM;
                end
            end
            FILL_DONE:   state_next = FILL_DONE;
            default:     state_next = FILL_ZERO;
        endcase
    end

    always_comb begin
        idx_next  = idx_reg;
        mant_next = mant_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        wr.en     = 1'b0;
        wr.addr   = idx_reg;
        wr.data   = res_reg;
        fill_done = 1'b0;
        case (state_reg)
            FILL_ZERO: begin
                wr.en    = 1'b1;
                wr.data  = '0;
                idx_next = TBL_AW'(1);
            end
            FILL_NORM: begin
                mant_next = MANT_W'(idx_reg) << shamt;
                res_next  = TBL_DW'(msb) << FRAC_BITS;
                cnt_next  = BIT_CNT_W'(FRAC_BITS);
            end
            FILL_SQUARE: begin
                if (sq_top[MANT_W]) begin
                    mant_next = sq_top[MANT_W:1];
                    res_next  = res_reg | (TBL_DW'(1) << (cnt_reg - BIT_CNT_W'(1)));
                end else begin
                    mant_next = sq_top[MANT_W-1:0];
                end
                cnt_next = cnt_reg - BIT_CNT_W'(1);
            end
            FILL_WRITE: begin
                wr.en = 1'b1;
                if (int'(idx_reg) != MAX_N) begin
                    idx_next = idx_reg + TBL_AW'(1);
                end
            end
            FILL_DONE: begin
                fill_done = 1'b1;
            end
            default: begin
                fill_done = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/bfpt_search.sv
// Trial-count search sequencer with log-probability accumulator and output register.
`default_nettype none

module bfpt_search
    import bfpt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rate_cfg_t         cfg,
    input  wire logic              fill_done,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [N_W-1:0]    s_minimizer_count,
    output tbl_rd_t                rd_req,
    input  wire logic [TBL_DW-1:0] rdata_a,
    input  wire logic [TBL_DW-1:0] rdata_b,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [CORR_W-1:0]      m_correction,
    output logic                   m_saturated
);

    srch_state_t              state_reg, state_next;
    logic [TBL_AW-1:0]        n_reg, n_next;
    logic [K_W-1:0]           k_reg, k_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [CFG_W:0]    delta_reg, delta_next;
    logic [CORR_W-1:0]        res_corr_reg, res_corr_next;
    logic                     res_sat_reg, res_sat_next;
    logic                     m_valid_reg, m_valid_next;
    logic [CORR_W-1:0]        m_corr_reg, m_corr_next;
    logic                     m_sat_reg, m_sat_next;

    logic [TBL_AW-1:0]        n_in;
    logic [TBL_AW-1:0]        n_less1;
    logic [K_W-1:0]           n_wide;
    logic [K_W-1:0]           k_plus1;
    logic                     accept;
    logic                     below;
    logic                     more;
    logic                     out_free;
    logic signed [SUM_W-1:0]  sum_load;
    logic signed [SUM_W-1:0]  sum_prod;
    logic signed [SUM_W-1:0]  sum_tbl;
    logic signed [SUM_W-1:0]  sum_delta;

    always_comb begin
        if (int'(s_minimizer_count) > MAX_N) begin
            n_in = TBL_AW'(MAX_N);
        end else begin
            n_in = TBL_AW'(s_minimizer_count);
        end
    end

    assign s_ready  = (state_reg == SRCH_IDLE) && fill_done;
    assign accept   = s_valid && s_ready;
    assign n_less1  = n_reg - TBL_AW'(1);
    assign n_wide   = K_W'(n_reg);
    assign k_plus1  = k_reg + K_W'(1);
    assign below    = acc_reg < ACC_W'(cfg.log_prob_limit);
    assign more     = k_reg < n_wide;
    assign out_free = !m_valid_reg || m_ready;

    assign sum_load  = $signed(SUM_W'(rdata_a)) + SUM_W'(cfg.log_false_rate);
    assign sum_prod  = SUM_W'(acc_reg) + SUM_W'(prod_reg);
    assign sum_tbl   = SUM_W'(acc_reg) + $signed(SUM_W'(rdata_a)) - $signed(SUM_W'(rdata_b));
    assign sum_delta = SUM_W'(acc_reg) + SUM_W'(delta_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SRCH_IDLE;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
            acc_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            k_reg       <= k_next;
            acc_reg     <= acc_next;
        end
        n_reg        <= n_next;
        prod_reg     <= prod_next;
        delta_reg    <= delta_next;
        res_corr_reg <= res_corr_next;
        res_sat_reg  <= res_sat_next;
        m_corr_reg   <= m_corr_next;
        m_sat_reg    <= m_sat_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SRCH_IDLE: begin
                if (accept) begin
                    if (n_in == '0) begin
                        state_next = SRCH_DONE;
                    end else begin
                        state_next = SRCH_LOAD;
                    end
                end
            end
            SRCH_LOAD: state_next = SRCH_INIT;
            SRCH_INIT: state_next = SRCH_TEST;
            SRCH_TEST: begin
                if (below || !more) begin
                    state_next = SRCH_DONE;
                end else begin
                    state_next = SRCH_ADD;
                end
            end
            SRCH_ADD:  state_next = SRCH_TEST;
            SRCH_DONE: begin
                if (out_free) begin
                    state_next = SRCH_IDLE;
                end
            end
            default:   state_next = SRCH_IDLE;
        endcase
    end

    always_comb begin
        n_next        = n_reg;
        k_next        = k_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        delta_next    = delta_reg;
        res_corr_next = res_corr_reg;
        res_sat_next  = res_sat_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_corr_next   = m_corr_reg;
        m_sat_next    = m_sat_reg;
        rd_req.addr_a = TBL_AW'(n_wide - k_reg);
        rd_req.addr_b = TBL_AW'(k_plus1);
        case (state_reg)
            SRCH_IDLE: begin
                rd_req.addr_a = n_in;
                if (accept) begin
                    n_next        = n_in;
                    k_next        = K_W'(1);
                    res_corr_next = '0;
                    res_sat_next  = 1'b1;
                end
            end
            SRCH_LOAD: begin
                acc_next   = sat_acc(sum_load);
                prod_next  = PROD_W'($signed({1'b0, n_less1})) * PROD_W'(cfg.log_true_rate);
                delta_next = (CFG_W+1)'(cfg.log_false_rate) - (CFG_W+1)'(cfg.log_true_rate);
            end
            SRCH_INIT: begin
                acc_next = sat_acc(sum_prod);
            end
            SRCH_TEST: begin
                if (below) begin
                    res_corr_next = CORR_W'(k_reg - K_W'(1));
                    res_sat_next  = 1'b0;
                end else if (more) begin
                    acc_next = sat_acc(sum_tbl);
                end else begin
                    k_next        = k_plus1;
                    res_corr_next = CORR_W'(k_reg);
                    res_sat_next  = 1'b1;
                end
            end
            SRCH_ADD: begin
                acc_next      = sat_acc(sum_delta);
                k_next        = k_plus1;
                rd_req.addr_a = TBL_AW'(n_wide - k_plus1);
                rd_req.addr_b = TBL_AW'(k_plus1 + K_W'(1));
            end
            SRCH_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_corr_next  = res_corr_reg;
                    m_sat_next   = res_sat_reg;
                end
            end
            default: begin
                m_valid_next = 1'b0;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_correction = m_corr_reg;
    assign m_saturated  = m_sat_reg;

endmodule

`default_nettype wire

>>> hdl/bfpt_checker.sv
// Port-level assertions for the binomial threshold search, bound to the top level.
`default_nettype none

module bfpt_checker
    import bfpt_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [CORR_W-1:0]    m_correction,
    input wire logic                 m_saturated
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_correction) && $stable(m_saturated))
        else $error("output transaction changed while stalled");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_reset_fill: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready during table sweep");

    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared one cycle after input transaction");

    a_unsat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_saturated |-> (int'(m_correction) < MAX_N))
        else $error("unsaturated correction out of range");

endmodule

bind binomial_false_positive_threshold bfpt_checker u_checker (.*);

`default_nettype wire
